// ===== rtl/core/sensor_frame_crc_receiver_macros.svh =====
// Assertion macros shared by the checker of the sensor frame CRC receiver.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef SENSOR_FRAME_CRC_RECEIVER_MACROS_SVH
`define SENSOR_FRAME_CRC_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFCR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcr assertion failed");

`endif

// ===== rtl/core/sfcr_pkg.sv =====
// Types and constants of the sensor frame CRC receiver.
// Used by the CRC byte unit, the top level and the checker; depends on nothing.
package sfcr_pkg;

    typedef logic [3:0]  pos_t;
    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;

    localparam word_t CRC_POLY = 16'hA001;
    localparam word_t CRC_INIT = 16'hFFFF;

    localparam pos_t FRAME_BYTES = 4'd11;
    localparam pos_t POS_FIRST   = 4'd0;
    localparam pos_t POS_LAST    = 4'd10;
    localparam pos_t POS_TEMP_HI = 4'd3;
    localparam pos_t POS_TEMP_LO = 4'd4;
    localparam pos_t POS_MOIST_HI = 4'd5;
    localparam pos_t POS_MOIST_LO = 4'd6;
    localparam pos_t POS_COND_HI = 4'd7;
    localparam pos_t POS_COND_LO = 4'd8;

endpackage

// ===== rtl/core/sensor_frame_crc_receiver.sv =====
// Sensor frame CRC receiver: one byte per transfer, one result per 11-byte frame.
// Throughput: one byte per cycle, set by the input register and the combinational
// CRC byte update, while no finished frame waits on a full, stalled output register;
// the output register takes each result and lets input go on while a result waits.
// Reset (asynchronous, active low) leaves the block idle with the CRC at 0xFFFF.
// Depends on sfcr_pkg and sfcr_crc_byte.
module sensor_frame_crc_receiver
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sfcr_pkg::byte_t rx_byte,
    input  logic            frame_start,
    output logic            out_valid,
    input  logic            out_stall,
    output sfcr_pkg::word_t temperature_raw,
    output sfcr_pkg::word_t moisture_raw,
    output sfcr_pkg::word_t conductivity_raw,
    output logic            crc_ok
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    sfcr_pkg::byte_t s1_byte_reg;
    logic            s1_start_reg;

    sfcr_pkg::pos_t  pos_reg;
    sfcr_pkg::pos_t  pos_next;
    sfcr_pkg::word_t crc_reg;
    sfcr_pkg::word_t crc_next;
    sfcr_pkg::word_t temp_reg;
    sfcr_pkg::word_t temp_next;
    sfcr_pkg::word_t moist_reg;
    sfcr_pkg::word_t moist_next;
    sfcr_pkg::word_t cond_reg;
    sfcr_pkg::word_t cond_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    sfcr_pkg::word_t out_temp_reg;
    sfcr_pkg::word_t out_moist_reg;
    sfcr_pkg::word_t out_cond_reg;
    logic            out_ok_reg;

    sfcr_pkg::pos_t  pos_cur;
    sfcr_pkg::word_t crc_cur;
    sfcr_pkg::word_t crc_upd;
    logic            take;
    logic            done;
    logic            out_free;
    logic            advance;
    logic            in_accept;

    sfcr_crc_byte u_crc
    (
        .crc_in  (crc_cur),
        .data_in (s1_byte_reg),
        .crc_out (crc_upd)
    );

    assign pos_cur  = s1_start_reg ? sfcr_pkg::POS_FIRST : pos_reg;
    assign crc_cur  = s1_start_reg ? sfcr_pkg::CRC_INIT : crc_reg;
    assign take     = s1_valid_reg && (s1_start_reg || (pos_reg < sfcr_pkg::FRAME_BYTES));
    assign done     = take && (pos_cur == sfcr_pkg::POS_LAST);
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!done || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        temp_next  = temp_reg;
        moist_next = moist_reg;
        cond_next  = cond_reg;
        case (pos_cur)
            sfcr_pkg::POS_TEMP_HI:  temp_next  = {s1_byte_reg, temp_reg[7:0]};
            sfcr_pkg::POS_TEMP_LO:  temp_next  = {temp_reg[15:8], s1_byte_reg};
            sfcr_pkg::POS_MOIST_HI: moist_next = {s1_byte_reg, moist_reg[7:0]};
            sfcr_pkg::POS_MOIST_LO: moist_next = {moist_reg[15:8], s1_byte_reg};
            sfcr_pkg::POS_COND_HI:  cond_next  = {s1_byte_reg, cond_reg[7:0]};
            sfcr_pkg::POS_COND_LO:  cond_next  = {cond_reg[15:8], s1_byte_reg};
            default:
            begin
            end
        endcase
        pos_next = pos_cur + 4'd1;
        crc_next = crc_upd;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= sfcr_pkg::FRAME_BYTES;
            crc_reg       <= sfcr_pkg::CRC_INIT;
            temp_reg      <= '0;
            moist_reg     <= '0;
            cond_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && take)
            begin
                pos_reg   <= pos_next;
                crc_reg   <= crc_next;
                temp_reg  <= temp_next;
                moist_reg <= moist_next;
                cond_reg  <= cond_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg  <= rx_byte;
            s1_start_reg <= frame_start;
        end
        if (advance && done)
        begin
            out_temp_reg  <= temp_next;
            out_moist_reg <= moist_next;
            out_cond_reg  <= cond_next;
            out_ok_reg    <= (crc_next == 16'h0000);
        end
    end

    assign out_valid        = out_valid_reg;
    assign temperature_raw  = out_temp_reg;
    assign moisture_raw     = out_moist_reg;
    assign conductivity_raw = out_cond_reg;
    assign crc_ok           = out_ok_reg;

endmodule

// ===== rtl/core/sfcr_crc_byte.sv =====
// Reflected CRC-16 update of one byte, eight shift steps unrolled.
// Depends on sfcr_pkg for the polynomial and the word types.
module sfcr_crc_byte
(
    input  sfcr_pkg::word_t crc_in,
    input  sfcr_pkg::byte_t data_in,
    output sfcr_pkg::word_t crc_out
);

    always_comb
    begin
        sfcr_pkg::word_t c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ sfcr_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// ===== rtl/core/sfcr_checker.sv =====
// Port-level checker of the sensor frame CRC receiver, with its bind statement.
// Depends on sfcr_pkg and sensor_frame_crc_receiver_macros.svh.
`include "sensor_frame_crc_receiver_macros.svh"

module sfcr_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input logic            frame_start,
    input logic            out_valid,
    input logic            out_stall,
    input sfcr_pkg::word_t temperature_raw,
    input sfcr_pkg::word_t moisture_raw,
    input sfcr_pkg::word_t conductivity_raw,
    input logic            crc_ok
);

    sfcr_pkg::pos_t chk_pos_reg;
    sfcr_pkg::pos_t chk_pos_next;
    sfcr_pkg::pos_t chk_pos_cur;
    logic [1:0]     pending_reg;
    logic [1:0]     pending_next;
    logic           in_xfer;
    logic           out_xfer;
    logic           taken;
    logic           completes;

    assign in_xfer     = in_valid && !in_stall;
    assign out_xfer    = out_valid && !out_stall;
    assign chk_pos_cur = frame_start ? sfcr_pkg::POS_FIRST : chk_pos_reg;
    assign taken       = in_xfer && (frame_start || (chk_pos_reg < sfcr_pkg::FRAME_BYTES));
    assign completes   = taken && (chk_pos_cur == sfcr_pkg::POS_LAST);

    always_comb
    begin
        chk_pos_next = chk_pos_reg;
        if (taken)
        begin
            chk_pos_next = chk_pos_cur + 4'd1;
        end
        pending_next = pending_reg + {1'b0, completes} - {1'b0, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_pos_reg <= sfcr_pkg::FRAME_BYTES;
            pending_reg <= 2'd0;
        end
        else
        begin
            chk_pos_reg <= chk_pos_next;
            pending_reg <= pending_next;
        end
    end

    // A result may only show up for a frame whose eleventh byte was transferred.
    `SFCR_ASSERT_IMPLY(a_result_has_frame, out_valid, pending_reg != 2'd0)

    // At most one finished frame waits inside and one at the output.
    `SFCR_ASSERT_IMPLY(a_pending_bounded, 1'b1, pending_reg != 2'd3)

    // A waiting result holds its payload while the receiver stalls it.
    `SFCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(temperature_raw) && $stable(moisture_raw)
        && $stable(conductivity_raw) && $stable(crc_ok))

    // The block never stalls input while its inner stage is empty and output is free.
    `SFCR_ASSERT_IMPLY(a_no_stall_when_drained, !out_valid && pending_reg == 2'd0
        && $past(!in_xfer), !in_stall)

endmodule

bind sensor_frame_crc_receiver sfcr_checker u_sfcr_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .frame_start      (frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .temperature_raw  (temperature_raw),
    .moisture_raw     (moisture_raw),
    .conductivity_raw (conductivity_raw),
    .crc_ok           (crc_ok)
);
